[hw/rtl/sts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Source token scanner package
// Shared types and constants for the scanner front, token queue and back end.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// Scanner mode, including the one byte of operator lookahead.
	typedef enum logic [3:0] {
		MODE_IDLE  = 4'd0,
		MODE_NUM   = 4'd1,
		MODE_IDENT = 4'd2,
		MODE_SLASH = 4'd3,
		MODE_LINE  = 4'd4,
		MODE_BLOCK = 4'd5,
		MODE_BSTAR = 4'd6,
		MODE_EQ    = 4'd7,
		MODE_BANG  = 4'd8,
		MODE_LT    = 4'd9,
		MODE_GT    = 4'd10,
		MODE_COLON = 4'd11
	} mode_t;

	typedef enum logic [4:0] {
		TK_EOF    = 5'd0,
		TK_BAD    = 5'd1,
		TK_OPEN   = 5'd2,
		TK_INT    = 5'd3,
		TK_IDENT  = 5'd4,
		TK_ADD    = 5'd5,
		TK_SUB    = 5'd6,
		TK_MULT   = 5'd7,
		TK_DIV    = 5'd8,
		TK_MOD    = 5'd9,
		TK_ASSIGN = 5'd10,
		TK_EQ     = 5'd11,
		TK_NEG    = 5'd12,
		TK_NE     = 5'd13,
		TK_LPAR   = 5'd14,
		TK_RPAR   = 5'd15,
		TK_LBRA   = 5'd16,
		TK_RBRA   = 5'd17,
		TK_SEP    = 5'd18,
		TK_OPSEP  = 5'd19,
		TK_LT     = 5'd20,
		TK_LE     = 5'd21,
		TK_GT     = 5'd22,
		TK_GE     = 5'd23,
		TK_DECL   = 5'd24
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [30:0] value;
		logic        ovf;
		logic [31:0] start;
		logic [15:0] len;
	} token_t;

	// All tokens caused by one source byte: one, or two when "two" is set.
	typedef struct packed {
		token_t first;
		token_t second;
		logic   two;
	} entry_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

	function automatic token_t simple_token(input tok_kind_t kind);
		token_t t;
		t       = '0;
		t.kind  = kind;
		return t;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/sts_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Source token scanner channels
// Valid/ready channels for source bytes in and tokens out.
// ----------------------------------------------------------------------------
interface sts_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_byte;

	modport source (output valid, output kind, output char_byte, input ready);
	modport sink (input valid, input kind, input char_byte, output ready);
endinterface

interface sts_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [30:0] int_value;
	logic        overflow;
	logic [31:0] ident_start;
	logic [15:0] ident_length;
	logic        last;

	modport source (output valid, output token_kind, output int_value, output overflow,
		output ident_start, output ident_length, output last, input ready);
	modport sink (input valid, input token_kind, input int_value, input overflow,
		input ident_start, input ident_length, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/sts_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner front end
// Classifies each source byte, advances the scan mode and builds its tokens.
// ----------------------------------------------------------------------------
module sts_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	sts_in_if.sink                  chars,
	input  wire sts_pkg::q_status_t qstat,
	output logic                    push,
	output sts_pkg::entry_t         push_entry
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	sts_pkg::mode_t mode_q, mode_d;
	logic [30:0]    acc_q, acc_d;
	logic           sat_q, sat_d;
	logic [31:0]    pos_q, pos_d;
	logic [31:0]    start_q, start_d;
	logic [15:0]    len_q, len_d;

	logic           accept;
	logic [7:0]     c;
	logic [3:0]     digit;
	logic [34:0]    acc_x10;

	sts_pkg::token_t pend_tok, idle_tok;
	logic            pend_v, idle_v;
	sts_pkg::mode_t  idle_mode;
	sts_pkg::tok_kind_t pair_kind;
	logic            any_tok;

	assign chars.ready = !qstat.full;
	assign accept      = chars.valid && chars.ready;
	assign c           = chars.char_byte;
	assign digit       = 4'(c - CH_ZERO);
	assign acc_x10     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, digit};

	// Token held pending by the current mode.
	always_comb begin
		pend_v   = 1'b1;
		pend_tok = '0;
		unique case (mode_q)
			sts_pkg::MODE_NUM: begin
				pend_tok.kind  = sts_pkg::TK_INT;
				pend_tok.value = acc_q;
				pend_tok.ovf   = sat_q;
			end
			sts_pkg::MODE_IDENT: begin
				pend_tok.kind  = sts_pkg::TK_IDENT;
				pend_tok.start = start_q;
				pend_tok.len   = len_q;
			end
			sts_pkg::MODE_SLASH: pend_tok = sts_pkg::simple_token(sts_pkg::TK_DIV);
			sts_pkg::MODE_EQ:    pend_tok = sts_pkg::simple_token(sts_pkg::TK_ASSIGN);
			sts_pkg::MODE_BANG:  pend_tok = sts_pkg::simple_token(sts_pkg::TK_NEG);
			sts_pkg::MODE_LT:    pend_tok = sts_pkg::simple_token(sts_pkg::TK_LT);
			sts_pkg::MODE_GT:    pend_tok = sts_pkg::simple_token(sts_pkg::TK_GT);
			sts_pkg::MODE_COLON: pend_tok = sts_pkg::simple_token(sts_pkg::TK_BAD);
			default:             pend_v   = 1'b0;
		endcase
	end

	// Two-character operator completed by '='.
	always_comb begin
		unique case (mode_q)
			sts_pkg::MODE_EQ:   pair_kind = sts_pkg::TK_EQ;
			sts_pkg::MODE_BANG: pair_kind = sts_pkg::TK_NE;
			sts_pkg::MODE_LT:   pair_kind = sts_pkg::TK_LE;
			sts_pkg::MODE_GT:   pair_kind = sts_pkg::TK_GE;
			default:            pair_kind = sts_pkg::TK_DECL;
		endcase
	end

	// A byte seen between tokens.
	always_comb begin
		idle_mode = sts_pkg::MODE_IDLE;
		idle_v    = 1'b0;
		idle_tok  = '0;
		priority if (is_space(c)) begin
			idle_v = 1'b0;
		end else if (is_digit(c)) begin
			idle_mode = sts_pkg::MODE_NUM;
		end else if (is_alpha(c)) begin
			idle_mode = sts_pkg::MODE_IDENT;
		end else begin
			unique case (c)
				"/": idle_mode = sts_pkg::MODE_SLASH;
				"=": idle_mode = sts_pkg::MODE_EQ;
				"!": idle_mode = sts_pkg::MODE_BANG;
				"<": idle_mode = sts_pkg::MODE_LT;
				">": idle_mode = sts_pkg::MODE_GT;
				":": idle_mode = sts_pkg::MODE_COLON;
				"+": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_ADD); end
				"-": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_SUB); end
				"*": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_MULT); end
				"%": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_MOD); end
				"(": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_LPAR); end
				")": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_RPAR); end
				"{": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_LBRA); end
				"}": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_RBRA); end
				";": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_SEP); end
				",": begin idle_v = 1'b1; idle_tok = sts_pkg::simple_token(sts_pkg::TK_OPSEP); end
				default: begin
					idle_v   = 1'b1;
					idle_tok = sts_pkg::simple_token(sts_pkg::TK_BAD);
				end
			endcase
		end
	end

	// Next state and the tokens of this byte.
	always_comb begin
		logic restart;
		restart    = 1'b0;
		mode_d     = mode_q;
		acc_d      = acc_q;
		sat_d      = sat_q;
		start_d    = start_q;
		len_d      = len_q;
		pos_d      = pos_q + 32'd1;
		any_tok    = 1'b0;
		push_entry = '0;

		if (chars.kind) begin
			// End of source: flush, then eof, then back to reset state.
			mode_d  = sts_pkg::MODE_IDLE;
			acc_d   = '0;
			sat_d   = 1'b0;
			pos_d   = '0;
			start_d = '0;
			len_d   = '0;
			any_tok = 1'b1;
			push_entry.second = sts_pkg::simple_token(sts_pkg::TK_EOF);
			if ((mode_q == sts_pkg::MODE_BLOCK) || (mode_q == sts_pkg::MODE_BSTAR)) begin
				push_entry.first = sts_pkg::simple_token(sts_pkg::TK_OPEN);
				push_entry.two   = 1'b1;
			end else if (pend_v) begin
				push_entry.first = pend_tok;
				push_entry.two   = 1'b1;
			end else begin
				push_entry.first = sts_pkg::simple_token(sts_pkg::TK_EOF);
			end
		end else begin
			unique case (mode_q)
				sts_pkg::MODE_NUM: begin
					if (is_digit(c)) begin
						if (acc_x10 > {4'd0, sts_pkg::INT_MAX}) begin
							acc_d = sts_pkg::INT_MAX;
							sat_d = 1'b1;
						end else begin
							acc_d = acc_x10[30:0];
						end
					end else begin
						restart = 1'b1;
					end
				end
				sts_pkg::MODE_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (len_q != sts_pkg::LEN_MAX) len_d = len_q + 16'd1;
					end else begin
						restart = 1'b1;
					end
				end
				sts_pkg::MODE_SLASH: begin
					if (c == "/") mode_d = sts_pkg::MODE_LINE;
					else if (c == "*") mode_d = sts_pkg::MODE_BLOCK;
					else restart = 1'b1;
				end
				sts_pkg::MODE_LINE: begin
					if (c == CH_NL) mode_d = sts_pkg::MODE_IDLE;
				end
				sts_pkg::MODE_BLOCK: begin
					if (c == "*") mode_d = sts_pkg::MODE_BSTAR;
				end
				sts_pkg::MODE_BSTAR: begin
					if (c == "/") mode_d = sts_pkg::MODE_IDLE;
					else if (c != "*") mode_d = sts_pkg::MODE_BLOCK;
				end
				sts_pkg::MODE_EQ, sts_pkg::MODE_BANG, sts_pkg::MODE_LT,
				sts_pkg::MODE_GT, sts_pkg::MODE_COLON: begin
					if (c == "=") begin
						mode_d           = sts_pkg::MODE_IDLE;
						any_tok          = 1'b1;
						push_entry.first = sts_pkg::simple_token(pair_kind);
					end else begin
						restart = 1'b1;
					end
				end
				default: restart = 1'b1;
			endcase

			// Flush whatever is pending and treat the byte as a fresh start.
			if (restart) begin
				mode_d = idle_mode;
				if (idle_mode == sts_pkg::MODE_NUM) begin
					acc_d = {27'd0, digit};
					sat_d = 1'b0;
				end
				if (idle_mode == sts_pkg::MODE_IDENT) begin
					start_d = pos_q;
					len_d   = 16'd1;
				end
				any_tok           = pend_v || idle_v;
				push_entry.first  = pend_v ? pend_tok : idle_tok;
				push_entry.second = idle_tok;
				push_entry.two    = pend_v && idle_v;
			end
		end
	end

	assign push = accept && any_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sts_pkg::MODE_IDLE;
			acc_q   <= '0;
			sat_q   <= 1'b0;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			sat_q   <= sat_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
		end
	end

`ifndef ASSERT_OFF
	a_eof_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && chars.kind) |=> (mode_q == sts_pkg::MODE_IDLE) && (pos_q == '0))
		else $error("scanner state not cleared after end of source");
`endif

endmodule
`default_nettype wire

[hw/rtl/sts_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token queue
// Short FIFO of per-byte token groups between the front end and the back end.
// ----------------------------------------------------------------------------
module sts_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sts_pkg::entry_t push_entry,
	input  wire logic            pop,
	output sts_pkg::q_status_t   qstat,
	output sts_pkg::entry_t      head
);

	sts_pkg::entry_t               mem_q [sts_pkg::QDEPTH];
	logic [sts_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sts_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sts_pkg::QCNT_W-1:0]    count_q;

	assign qstat.full     = (count_q == sts_pkg::QCNT_W'(sts_pkg::QDEPTH));
	assign qstat.nonempty = (count_q != '0);
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!qstat.full || pop))
		else $error("token queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.nonempty)
		else $error("token queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sts_pkg::QCNT_W'(sts_pkg::QDEPTH))
		else $error("token queue count beyond depth");
`endif

endmodule
`default_nettype wire

[hw/rtl/sts_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token back end
// Sends the tokens of each queued group one by one through an output register.
// ----------------------------------------------------------------------------
module sts_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sts_pkg::q_status_t qstat,
	input  wire sts_pkg::entry_t    head,
	output logic                    pop,
	sts_tok_if.source               tokens
);

	logic            phase_q;
	logic            out_v_q;
	sts_pkg::token_t out_q;
	logic            last_q;
	logic            load;

	assign load = qstat.nonempty && (!out_v_q || tokens.ready);
	assign pop  = load && (phase_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				phase_q <= !phase_q && head.two;
			end else if (tokens.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= phase_q ? head.second : head.first;
			last_q <= phase_q || !head.two;
		end
	end

	assign tokens.valid        = out_v_q;
	assign tokens.token_kind   = out_q.kind;
	assign tokens.int_value    = out_q.value;
	assign tokens.overflow     = out_q.ovf;
	assign tokens.ident_start  = out_q.start;
	assign tokens.ident_length = out_q.len;
	assign tokens.last         = last_q;

`ifndef ASSERT_OFF
	a_phase_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (qstat.nonempty && head.two))
		else $error("second token pending without a two-token group");
`endif

endmodule
`default_nettype wire

[hw/rtl/source_token_scanner_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Source token scanner
// Streaming lexer: source bytes in, integer, identifier, operator and error
// tokens out.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                                           takes
//   chars     in    kind, char_byte                                   valid & ready
//   tokens    out   token_kind, int_value, overflow, ident_start,     valid & ready
//                   ident_length, last
//
// The scanner accepts one source byte per cycle while the token queue has room.
// A byte that causes two tokens sends them in turn from one queue entry. One
// token leaves per cycle while tokens.ready is high and the queue is not empty;
// the first token of a byte passes through the queue, then the output register.
// Reset clears the scan mode, counters and queue; no clearing pass is needed.
// A stalled token output fills the four-entry queue, then drops chars.ready.
// ----------------------------------------------------------------------------
module source_token_scanner_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	sts_in_if.sink    chars,
	sts_tok_if.source tokens
);

	// Front end to queue: the token group of each accepted byte.
	logic               push;
	sts_pkg::entry_t    push_entry;

	// Queue to back end: fill status and the oldest group.
	sts_pkg::q_status_t qstat;
	sts_pkg::entry_t    head;
	logic               pop;

	// The front end classifies each byte and holds the scanner state, including
	// the lookahead byte for two-character operators and comment openers.
	sts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// The queue lets the scanner keep running while the token sink stalls.
	sts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.qstat      (qstat),
		.head       (head)
	);

	// The back end splits two-token groups and marks the last token of a byte.
	sts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule
`default_nettype wire

[tb/source_token_scanner_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source token scanner testbench
// Streams source bytes and end-of-source marks into the scanner and checks
// every emitted token, field by field, against a cycle-free software lexer
// kept inside this module. Directed strings cover each operator, the pending
// lookahead cases, comments, bad bytes, saturation of numbers and a long
// identifier. Random, mostly well-formed source text follows, under
// several patterns of idle input and stalled output.
// ----------------------------------------------------------------------------
module source_token_scanner_unit_tb;

	// The run is cut off here if the scanner stops making progress.
	localparam int CYCLE_LIMIT = 1_000_000;

	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = " ";
	localparam logic [7:0] CH_STAR    = "*";
	localparam logic [7:0] CH_SLASH   = "/";
	localparam logic [7:0] CH_EQUALS  = "=";
	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_UPPER_A = "A";

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// One expected token together with the flag that closes its request.
	typedef struct packed {
		sts_pkg::token_t tok;
		logic            last;
	} token_due_t;

	logic clk = 1'b0;
	logic arst_n;

	sts_in_if  chars_if ();
	sts_tok_if tokens_if ();

	source_token_scanner_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Tokens predicted for accepted requests and not yet seen at the output.
	token_due_t      tokens_due[$];
	// Tokens caused by the request that is being predicted right now.
	sts_pkg::token_t step_tokens[$];

	int mismatches = 0;
	int cycle_count = 0;
	int requests_sent;
	int sender_idle_pct;
	int sink_stall_pct;

	// Lexer state mirrored in the testbench.
	sts_pkg::mode_t lex_mode;
	logic [30:0]    num_acc;
	logic           num_sat;
	logic [31:0]    byte_pos;
	logic [31:0]    id_start;
	logic [15:0]    id_len;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic sts_pkg::token_t make_token(input sts_pkg::tok_kind_t kind,
		input logic [30:0] value, input logic ovf, input logic [31:0] start,
		input logic [15:0] len);
		sts_pkg::token_t t;
		t.kind  = kind;
		t.value = value;
		t.ovf   = ovf;
		t.start = start;
		t.len   = len;
		return t;
	endfunction

	function automatic logic [7:0] rand_alpha();
		logic [7:0] base;
		base = $urandom_range(1) ? CH_LOWER_A : CH_UPPER_A;
		return base + 8'($urandom_range(25));
	endfunction

	task reset_lexer_state();
		lex_mode = sts_pkg::MODE_IDLE;
		num_acc  = '0;
		num_sat  = 1'b0;
		byte_pos = '0;
		id_start = '0;
		id_len   = '0;
	endtask

	// Emit whatever token the current mode still holds, then go idle.
	task flush_held_token();
		case (lex_mode)
			sts_pkg::MODE_NUM:
				step_tokens.push_back(make_token(sts_pkg::TK_INT, num_acc, num_sat, '0, '0));
			sts_pkg::MODE_IDENT:
				step_tokens.push_back(make_token(sts_pkg::TK_IDENT, '0, 1'b0, id_start, id_len));
			sts_pkg::MODE_SLASH:
				step_tokens.push_back(make_token(sts_pkg::TK_DIV, '0, 1'b0, '0, '0));
			sts_pkg::MODE_EQ:
				step_tokens.push_back(make_token(sts_pkg::TK_ASSIGN, '0, 1'b0, '0, '0));
			sts_pkg::MODE_BANG:
				step_tokens.push_back(make_token(sts_pkg::TK_NEG, '0, 1'b0, '0, '0));
			sts_pkg::MODE_LT:
				step_tokens.push_back(make_token(sts_pkg::TK_LT, '0, 1'b0, '0, '0));
			sts_pkg::MODE_GT:
				step_tokens.push_back(make_token(sts_pkg::TK_GT, '0, 1'b0, '0, '0));
			sts_pkg::MODE_COLON:
				step_tokens.push_back(make_token(sts_pkg::TK_BAD, '0, 1'b0, '0, '0));
			default: ;
		endcase
		lex_mode = sts_pkg::MODE_IDLE;
	endtask

	// A byte seen between tokens: it starts a token, holds an operator for
	// lookahead, emits a single-character token, or is skipped as whitespace.
	task start_token(input logic [7:0] c, input logic [31:0] pos);
		sts_pkg::tok_kind_t single;
		lex_mode = sts_pkg::MODE_IDLE;
		single   = sts_pkg::TK_BAD;
		if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
			return;
		end else if (is_digit(c)) begin
			lex_mode = sts_pkg::MODE_NUM;
			num_acc  = 31'(c - CH_ZERO);
			num_sat  = 1'b0;
			return;
		end else if (is_alpha(c)) begin
			lex_mode = sts_pkg::MODE_IDENT;
			id_start = pos;
			id_len   = 16'd1;
			return;
		end
		case (c)
			"/": lex_mode = sts_pkg::MODE_SLASH;
			"=": lex_mode = sts_pkg::MODE_EQ;
			"!": lex_mode = sts_pkg::MODE_BANG;
			"<": lex_mode = sts_pkg::MODE_LT;
			">": lex_mode = sts_pkg::MODE_GT;
			":": lex_mode = sts_pkg::MODE_COLON;
			"+": single = sts_pkg::TK_ADD;
			"-": single = sts_pkg::TK_SUB;
			"*": single = sts_pkg::TK_MULT;
			"%": single = sts_pkg::TK_MOD;
			"(": single = sts_pkg::TK_LPAR;
			")": single = sts_pkg::TK_RPAR;
			"{": single = sts_pkg::TK_LBRA;
			"}": single = sts_pkg::TK_RBRA;
			";": single = sts_pkg::TK_SEP;
			",": single = sts_pkg::TK_OPSEP;
			default: ;
		endcase
		if (lex_mode == sts_pkg::MODE_IDLE)
			step_tokens.push_back(make_token(single, '0, 1'b0, '0, '0));
	endtask

	// Second byte after an operator that may pair with '='.
	task pair_or_restart(input logic [7:0] c, input logic [31:0] pos,
		input sts_pkg::tok_kind_t two);
		if (c == CH_EQUALS) begin
			step_tokens.push_back(make_token(two, '0, 1'b0, '0, '0));
			lex_mode = sts_pkg::MODE_IDLE;
		end else begin
			flush_held_token();
			start_token(c, pos);
		end
	endtask

	// Work out every token one accepted request causes and queue them.
	task predict_tokens(input logic kind, input logic [7:0] c);
		logic [31:0]       pos;
		longint unsigned   grown;
		step_tokens.delete();
		if (kind == KIND_END) begin
			if (lex_mode == sts_pkg::MODE_BLOCK || lex_mode == sts_pkg::MODE_BSTAR)
				step_tokens.push_back(make_token(sts_pkg::TK_OPEN, '0, 1'b0, '0, '0));
			else
				flush_held_token();
			step_tokens.push_back(make_token(sts_pkg::TK_EOF, '0, 1'b0, '0, '0));
			reset_lexer_state();
		end else begin
			pos = byte_pos;
			case (lex_mode)
				sts_pkg::MODE_NUM: begin
					if (is_digit(c)) begin
						grown = 64'(num_acc) * 64'd10 + 64'(c - CH_ZERO);
						if (grown > 64'(sts_pkg::INT_MAX)) begin
							num_acc = sts_pkg::INT_MAX;
							num_sat = 1'b1;
						end else begin
							num_acc = grown[30:0];
						end
					end else begin
						flush_held_token();
						start_token(c, pos);
					end
				end
				sts_pkg::MODE_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (id_len < sts_pkg::LEN_MAX)
							id_len = id_len + 16'd1;
					end else begin
						flush_held_token();
						start_token(c, pos);
					end
				end
				sts_pkg::MODE_SLASH: begin
					if (c == CH_SLASH) begin
						lex_mode = sts_pkg::MODE_LINE;
					end else if (c == CH_STAR) begin
						lex_mode = sts_pkg::MODE_BLOCK;
					end else begin
						flush_held_token();
						start_token(c, pos);
					end
				end
				sts_pkg::MODE_LINE: begin
					if (c == CH_NL)
						lex_mode = sts_pkg::MODE_IDLE;
				end
				sts_pkg::MODE_BLOCK: begin
					if (c == CH_STAR)
						lex_mode = sts_pkg::MODE_BSTAR;
				end
				sts_pkg::MODE_BSTAR: begin
					if (c == CH_SLASH)
						lex_mode = sts_pkg::MODE_IDLE;
					else if (c != CH_STAR)
						lex_mode = sts_pkg::MODE_BLOCK;
				end
				sts_pkg::MODE_EQ:    pair_or_restart(c, pos, sts_pkg::TK_EQ);
				sts_pkg::MODE_BANG:  pair_or_restart(c, pos, sts_pkg::TK_NE);
				sts_pkg::MODE_LT:    pair_or_restart(c, pos, sts_pkg::TK_LE);
				sts_pkg::MODE_GT:    pair_or_restart(c, pos, sts_pkg::TK_GE);
				sts_pkg::MODE_COLON: pair_or_restart(c, pos, sts_pkg::TK_DECL);
				default:             start_token(c, pos);
			endcase
			byte_pos = pos + 32'd1;
		end
		foreach (step_tokens[i])
			tokens_due.push_back('{tok: step_tokens[i], last: (i == step_tokens.size() - 1)});
	endtask

	// Present one request at a falling edge, possibly after a random idle
	// stretch, and hold it until the scanner takes it at a rising edge.
	task send_request(input logic kind, input logic [7:0] c);
		@(negedge clk);
		if ($urandom_range(99) < sender_idle_pct) begin
			chars_if.valid     <= 1'b0;
			chars_if.kind      <= 1'($urandom_range(1));
			chars_if.char_byte <= 8'($urandom_range(255));
			do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		chars_if.valid     <= 1'b1;
		chars_if.kind      <= kind;
		chars_if.char_byte <= c;
		do @(posedge clk); while (chars_if.ready !== 1'b1);
		requests_sent++;
		predict_tokens(kind, c);
	endtask

	task send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_request(KIND_CHAR, s[i]);
	endtask

	task set_pressure(input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
	endtask

	// Every single-character operator, every pair with '=', and each
	// lookahead operator flushed by the byte after it. The last colon is
	// still held at the end of source and comes out as a bad character.
	task test_operators();
		set_pressure(0, 0);
		send_text("+-*%(){};,==!=<=>=:=/=!<>:");
		send_request(KIND_END, 8'h00);
	endtask

	// The largest value that fits, and one that saturates with overflow.
	task test_numbers();
		set_pressure(61, 0);
		send_text("2147483647 21474836470");
		send_request(KIND_END, 8'hFF);
	endtask

	// Identifiers ended by an operator and by the end of source.
	task test_identifiers();
		set_pressure(0, 61);
		send_text("Zz09 a1=q");
		send_request(KIND_END, 8'h5A);
	endtask

	// Line and block comments, a star run before the closing slash, and a
	// block comment still open at the end of source.
	task test_comments();
		set_pressure(9, 9);
		send_text("//a*/");
		send_request(KIND_CHAR, CH_NL);
		send_text("7/* x **/8/**");
		send_request(KIND_END, 8'h00);
		send_text("//");
		send_request(KIND_END, 8'h2A);
	endtask

	// High bytes, a control byte and '#' are bad characters; all six
	// whitespace bytes are skipped; a colon followed by a letter is bad.
	task test_bad_and_space();
		set_pressure(9, 9);
		send_request(KIND_CHAR, 8'h80);
		send_request(KIND_CHAR, 8'hFF);
		send_request(KIND_CHAR, 8'h00);
		send_text("#\t\n");
		send_request(KIND_CHAR, 8'h0B);
		send_request(KIND_CHAR, 8'h0C);
		send_text("\r :x");
		send_request(KIND_END, 8'h00);
	endtask

	// A long identifier of mixed letters and digits, sent at full rate.
	task test_long_identifier();
		set_pressure(0, 0);
		send_request(KIND_CHAR, CH_UPPER_A);
		for (int i = 0; i < 30; i++)
			send_request(KIND_CHAR, (i % 3 == 0) ? CH_ZERO + 8'(i % 10) : rand_alpha());
		send_request(KIND_END, 8'h00);
	endtask

	// One random piece of source text: mostly well-formed tokens, comments
	// and whitespace, with some raw noise bytes and end-of-source marks.
	task send_piece();
		int         pick;
		int         count;
		logic [7:0] b;
		string      ops;
		ops  = "+-*/%=!(){};,<>:";
		pick = $urandom_range(99);
		if (pick < 18) begin
			count = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4, 1);
			repeat (count) send_request(KIND_CHAR, CH_ZERO + 8'($urandom_range(9)));
		end else if (pick < 36) begin
			send_request(KIND_CHAR, rand_alpha());
			repeat ($urandom_range(7))
				send_request(KIND_CHAR, ($urandom_range(2) == 0) ?
					CH_ZERO + 8'($urandom_range(9)) : rand_alpha());
		end else if (pick < 60) begin
			send_request(KIND_CHAR, ops[$urandom_range(ops.len() - 1)]);
			if ($urandom_range(2) == 0)
				send_request(KIND_CHAR, CH_EQUALS);
		end else if (pick < 72) begin
			send_request(KIND_CHAR, $urandom_range(1) ? CH_SPACE : 8'($urandom_range(13, 9)));
		end else if (pick < 78) begin
			send_text("//");
			repeat ($urandom_range(5)) begin
				b = 8'($urandom_range(255));
				send_request(KIND_CHAR, (b == CH_NL) ? CH_STAR : b);
			end
			if ($urandom_range(4) != 0)
				send_request(KIND_CHAR, CH_NL);
		end else if (pick < 85) begin
			send_text("/*");
			repeat ($urandom_range(6))
				send_request(KIND_CHAR, ($urandom_range(2) == 0) ?
					CH_STAR : 8'($urandom_range(255)));
			if ($urandom_range(4) != 0)
				send_text("*/");
		end else if (pick < 95) begin
			send_request(KIND_CHAR, 8'($urandom_range(255)));
		end else begin
			send_request(KIND_END, 8'($urandom_range(255)));
		end
	endtask

	// Random text under each pressure pattern in turn, free flow first.
	task test_random_text();
		int goal;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_pressure(0, 0);
				1: set_pressure(61, 0);
				2: set_pressure(0, 61);
				default: set_pressure(9, 9);
			endcase
			goal = requests_sent + 105;
			while (requests_sent < goal)
				send_piece();
		end
		send_request(KIND_END, 8'h00);
	endtask

	task report_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// The output side stalls at random, decided at each falling edge.
	always @(negedge clk)
		tokens_if.ready <= ($urandom_range(99) >= sink_stall_pct);

	// Every token taken at a rising edge is matched against the oldest
	// prediction.
	always @(posedge clk) begin : check_tokens
		token_due_t want;
		if (arst_n === 1'b1 && tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1) begin
			if (tokens_due.size() == 0) begin
				$error("token_kind: expected none, got %0d", tokens_if.token_kind);
				mismatches++;
			end else begin
				want = tokens_due.pop_front();
				report_field("token_kind", 64'(want.tok.kind), 64'(tokens_if.token_kind));
				report_field("int_value", 64'(want.tok.value), 64'(tokens_if.int_value));
				report_field("overflow", 64'(want.tok.ovf), 64'(tokens_if.overflow));
				report_field("ident_start", 64'(want.tok.start), 64'(tokens_if.ident_start));
				report_field("ident_length", 64'(want.tok.len), 64'(tokens_if.ident_length));
				report_field("last", 64'(want.last), 64'(tokens_if.last));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("source_token_scanner_unit: mismatch");
			$finish;
		end
	end

	initial begin
		requests_sent      = 0;
		sender_idle_pct    = 0;
		sink_stall_pct     = 0;
		arst_n             = 1'b0;
		chars_if.valid     = 1'b0;
		chars_if.kind      = KIND_CHAR;
		chars_if.char_byte = 8'h00;
		reset_lexer_state();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_operators();
		test_numbers();
		test_identifiers();
		test_comments();
		test_bad_and_space();
		test_long_identifier();
		test_random_text();

		@(negedge clk);
		chars_if.valid <= 1'b0;

		// Let every predicted token drain, then watch a little longer for
		// anything the scanner emits without cause.
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("source_token_scanner_unit: match");
		else
			$display("source_token_scanner_unit: mismatch");
		$finish;
	end

endmodule

[source_token_scanner_unit.f]
hw/rtl/sts_pkg.sv
hw/rtl/sts_if.sv
hw/rtl/sts_front.sv
hw/rtl/sts_queue.sv
hw/rtl/sts_back.sv
hw/rtl/source_token_scanner_unit.sv
tb/source_token_scanner_unit_tb.sv
